// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define APL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define APL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/apl_pkg.sv
package apl_pkg;

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int GAIN_REG_W = 48;
    localparam int LIM_W      = 31;
    localparam int DT_W       = 24;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int FLAG_W     = 3;
    localparam int AX_IDX_W   = 3;

    // Shared multiplier: signed 33 x signed 25
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Net force in Q.20, split for the two inverse-mass partial products
    localparam int NET_W       = 51;
    localparam int NET_FRAC_SH = 4;
    localparam int LO_W        = 24;
    localparam int HI_W        = NET_W - NET_FRAC_SH - LO_W;
    localparam int LOP_W       = GAIN_W + LO_W;
    localparam int ACC_W       = 64;
    localparam int ACC_FRAC    = 16;
    localparam int ACCQ_W      = ACC_W - ACC_FRAC;
    localparam int INC_W       = MUL_P_W - DT_W;
    localparam int SUM_W       = 35;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMASS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VLIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DT    = 3'd5;

    // Per-axis sequencer steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KD,
        ST_KS,
        ST_NET,
        ST_LO,
        ST_HI,
        ST_ACC,
        ST_AV,
        ST_VEL,
        ST_VD,
        ST_POS,
        ST_DONE
    } t_state;

endpackage

// File: rtl/admittance_position_loop_top.sv
// Admittance position loop: one control tick per input beat. For each axis the
// block forms net = force - kd*velocity - ks*(position - goal), scales it by the
// inverse mass, clamps acceleration, integrates and clamps velocity, integrates
// and saturates position, and returns the new positions with clamp flags. All
// products go through one shared 33x25 signed multiplier under a sequencer that
// steps each axis through KD, KS, NET, LO, HI, ACC, AV, VEL, VD and POS, between
// an accept state and a load state that waits on m_axis_tready while a result is
// pending. s_axis_tready is high only between ticks. Axes past the third see zero
// gains and report no flags. The user writes gains, limits and the period through
// the configuration port only while idle; the block itself does not enforce it.
`include "assert_macros.svh"

module admittance_position_loop_top
    import apl_pkg::*;
#(
    parameter int AXES = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_data,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // fields from bit 0: force_x, force_y, force_z, goal_x, goal_y, goal_z
    input  logic [2*AXES*DATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // fields from bit 0: command_x, command_y, command_z, accel_clamped,
    // velocity_clamped, zero pad
    output logic [((AXES*DATA_W+2*FLAG_W+7)/8)*8-1:0] m_axis_tdata
);

    localparam int AXIS_W   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int OUT_BITS = AXES*DATA_W + 2*FLAG_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int PAD_W    = OUT_W - OUT_BITS;

    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    // Gain of one axis from a packed register; zero past the third axis
    function automatic logic [GAIN_W-1:0] gain_sel(
        input logic [GAIN_REG_W-1:0] gains,
        input logic [AX_IDX_W-1:0]   axis
    );
        logic [GAIN_W-1:0] g;
        unique case (axis)
            3'd0:    g = gains[GAIN_W-1:0];
            3'd1:    g = gains[2*GAIN_W-1:GAIN_W];
            3'd2:    g = gains[3*GAIN_W-1:2*GAIN_W];
            default: g = '0;
        endcase
        return g;
    endfunction

    // Configuration registers
    logic [GAIN_REG_W-1:0] r_imass, r_kd, r_ks;
    logic [LIM_W-1:0]      r_alim, r_vlim;
    logic [DT_W-1:0]       r_dt;

    // Loop state and sequencer
    t_state                    r_state, n_state;
    logic [AXIS_W-1:0]         r_axis;
    logic signed [DATA_W-1:0]  r_vel   [AXES];
    logic signed [DATA_W-1:0]  r_pos   [AXES];
    logic signed [DATA_W-1:0]  r_force [AXES];
    logic signed [DATA_W-1:0]  r_goal  [AXES];

    // Working registers
    logic signed [MUL_P_W-1:0] r_prod;
    logic signed [NET_W-1:0]   r_net;
    logic signed [DATA_W:0]    r_err;
    logic [LOP_W-1:0]          r_lo;
    logic signed [DATA_W-1:0]  r_acc;
    logic [FLAG_W-1:0]         r_aflags, r_vflags;

    // Result register
    logic                      r_ovalid;
    logic signed [DATA_W-1:0]  r_cmd [AXES];
    logic [FLAG_W-1:0]         r_oaflags, r_ovflags;

    logic                      w_load;
    logic                      w_last;
    logic [AX_IDX_W-1:0]       w_axis3;
    logic [GAIN_W-1:0]         w_im, w_kd, w_ks;
    logic signed [DATA_W-1:0]  w_vel_cur, w_pos_cur, w_force, w_goal;
    logic signed [NET_W-1:0]   w_force_ext;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic signed [ACC_W-1:0]   w_acc_full;
    logic signed [ACCQ_W-1:0]  w_acc_q, w_alim_x;
    logic signed [DATA_W-1:0]  w_acc_clamp;
    logic                      w_ahit;
    logic signed [INC_W-1:0]   w_inc;
    logic signed [SUM_W-1:0]   w_vsum, w_vlim_x, w_psum;
    logic signed [DATA_W-1:0]  w_vel_clamp, w_pos_sat;
    logic                      w_vhit;
    logic signed [DATA_W:0]    w_vel_ext, w_vlim_ext;

    // Current-axis selects
    assign w_last    = (r_axis == AXIS_W'(AXES - 1));
    assign w_axis3   = AX_IDX_W'(r_axis);
    assign w_im      = gain_sel(r_imass, w_axis3);
    assign w_kd      = gain_sel(r_kd, w_axis3);
    assign w_ks      = gain_sel(r_ks, w_axis3);
    assign w_vel_cur = r_vel[r_axis];
    assign w_pos_cur = r_pos[r_axis];
    assign w_force   = r_force[r_axis];
    assign w_goal    = r_goal[r_axis];
    assign w_force_ext = {{(NET_W-DATA_W){w_force[DATA_W-1]}}, w_force};

    // Shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_KD: begin
                w_mul_a = {{(MUL_A_W-DATA_W){w_vel_cur[DATA_W-1]}}, w_vel_cur};
                w_mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, w_kd};
            end
            ST_KS: begin
                w_mul_a = r_err;
                w_mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, w_ks};
            end
            ST_LO: begin
                w_mul_a = {{(MUL_A_W-LO_W){1'b0}}, r_net[NET_FRAC_SH +: LO_W]};
                w_mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, w_im};
            end
            ST_HI: begin
                w_mul_a = {{(MUL_A_W-HI_W){r_net[NET_W-1]}},
                           r_net[NET_W-1:NET_FRAC_SH+LO_W]};
                w_mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, w_im};
            end
            ST_AV: begin
                w_mul_a = {{(MUL_A_W-DATA_W){r_acc[DATA_W-1]}}, r_acc};
                w_mul_b = {{(MUL_B_W-DT_W){1'b0}}, r_dt};
            end
            ST_VD: begin
                w_mul_a = {{(MUL_A_W-DATA_W){w_vel_cur[DATA_W-1]}}, w_vel_cur};
                w_mul_b = {{(MUL_B_W-DT_W){1'b0}}, r_dt};
            end
            default: begin
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Acceleration: join the two partial products, floor to Q16.16, clamp
    assign w_acc_full = ({{(ACC_W-MUL_P_W){r_prod[MUL_P_W-1]}}, r_prod} <<< LO_W)
                      + {{(ACC_W-LOP_W){1'b0}}, r_lo};
    assign w_acc_q    = w_acc_full[ACC_W-1:ACC_FRAC];
    assign w_alim_x   = {{(ACCQ_W-LIM_W){1'b0}}, r_alim};

    always_comb begin
        logic signed [ACCQ_W-1:0] neg_alim;
        neg_alim    = -w_alim_x;
        w_ahit      = 1'b1;
        w_acc_clamp = w_acc_q[DATA_W-1:0];
        priority if (w_acc_q > w_alim_x) begin
            w_acc_clamp = w_alim_x[DATA_W-1:0];
        end else if (w_acc_q < neg_alim) begin
            w_acc_clamp = neg_alim[DATA_W-1:0];
        end else begin
            w_ahit = 1'b0;
        end
    end

    // Velocity and position increments are floor(product / 2^24)
    assign w_inc    = r_prod[MUL_P_W-1:DT_W];
    assign w_vsum   = {{(SUM_W-DATA_W){w_vel_cur[DATA_W-1]}}, w_vel_cur}
                    + {{(SUM_W-INC_W){w_inc[INC_W-1]}}, w_inc};
    assign w_vlim_x = {{(SUM_W-LIM_W){1'b0}}, r_vlim};
    assign w_psum   = {{(SUM_W-DATA_W){w_pos_cur[DATA_W-1]}}, w_pos_cur}
                    + {{(SUM_W-INC_W){w_inc[INC_W-1]}}, w_inc};

    always_comb begin
        logic signed [SUM_W-1:0] neg_lim;
        neg_lim     = -w_vlim_x;
        w_vhit      = 1'b1;
        w_vel_clamp = w_vsum[DATA_W-1:0];
        priority if (w_vsum > w_vlim_x) begin
            w_vel_clamp = w_vlim_x[DATA_W-1:0];
        end else if (w_vsum < neg_lim) begin
            w_vel_clamp = neg_lim[DATA_W-1:0];
        end else begin
            w_vhit = 1'b0;
        end
    end

    always_comb begin
        priority if (w_psum > POS_MAX) begin
            w_pos_sat = POS_MAX[DATA_W-1:0];
        end else if (w_psum < POS_MIN) begin
            w_pos_sat = POS_MIN[DATA_W-1:0];
        end else begin
            w_pos_sat = w_psum[DATA_W-1:0];
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, input ready and result load
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_KD;
                end
            end
            ST_KD:  n_state = ST_KS;
            ST_KS:  n_state = ST_NET;
            ST_NET: n_state = ST_LO;
            ST_LO:  n_state = ST_HI;
            ST_HI:  n_state = ST_ACC;
            ST_ACC: n_state = ST_AV;
            ST_AV:  n_state = ST_VEL;
            ST_VEL: n_state = ST_VD;
            ST_VD:  n_state = ST_POS;
            ST_POS: n_state = w_last ? ST_DONE : ST_KD;
            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, loop state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imass  <= '0;
            r_kd     <= '0;
            r_ks     <= '0;
            r_alim   <= '0;
            r_vlim   <= '0;
            r_dt     <= '0;
            r_axis   <= '0;
            r_aflags <= '0;
            r_vflags <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_vel[k] <= '0;
                r_pos[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IMASS: r_imass <= i_cfg_data[GAIN_REG_W-1:0];
                    CFG_KD:    r_kd    <= i_cfg_data[GAIN_REG_W-1:0];
                    CFG_KS:    r_ks    <= i_cfg_data[GAIN_REG_W-1:0];
                    CFG_ALIM:  r_alim  <= i_cfg_data[LIM_W-1:0];
                    CFG_VLIM:  r_vlim  <= i_cfg_data[LIM_W-1:0];
                    CFG_DT:    r_dt    <= i_cfg_data[DT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int k = 0; k < AXES; k++) begin
                            r_force[k] <= s_axis_tdata[k*DATA_W +: DATA_W];
                            r_goal[k]  <= s_axis_tdata[(AXES+k)*DATA_W +: DATA_W];
                        end
                        r_axis   <= '0;
                        r_aflags <= '0;
                        r_vflags <= '0;
                    end
                end
                ST_KD: begin
                    r_prod <= w_prod;
                    r_net  <= w_force_ext <<< NET_FRAC_SH;
                    r_err  <= {w_pos_cur[DATA_W-1], w_pos_cur}
                            - {w_goal[DATA_W-1], w_goal};
                end
                ST_KS: begin
                    r_prod <= w_prod;
                    r_net  <= r_net - r_prod[NET_W-1:0];
                end
                ST_NET: begin
                    r_net <= r_net - r_prod[NET_W-1:0];
                end
                ST_LO: begin
                    r_prod <= w_prod;
                end
                ST_HI: begin
                    r_prod <= w_prod;
                    r_lo   <= r_prod[LOP_W-1:0];
                end
                ST_ACC: begin
                    r_acc <= w_acc_clamp;
                    for (int k = 0; k < FLAG_W; k++) begin
                        if (w_axis3 == AX_IDX_W'(k)) begin
                            r_aflags[k] <= w_ahit;
                        end
                    end
                end
                ST_AV: begin
                    r_prod <= w_prod;
                end
                ST_VEL: begin
                    r_vel[r_axis] <= w_vel_clamp;
                    for (int k = 0; k < FLAG_W; k++) begin
                        if (w_axis3 == AX_IDX_W'(k)) begin
                            r_vflags[k] <= w_vhit;
                        end
                    end
                end
                ST_VD: begin
                    r_prod <= w_prod;
                end
                ST_POS: begin
                    r_pos[r_axis] <= w_pos_sat;
                    if (!w_last) begin
                        r_axis <= r_axis + AXIS_W'(1);
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        for (int k = 0; k < AXES; k++) begin
                            r_cmd[k] <= r_pos[k];
                        end
                        r_oaflags <= r_aflags;
                        r_ovflags <= r_vflags;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result beat
    assign m_axis_tvalid = r_ovalid;

    for (genvar g = 0; g < AXES; g++) begin : g_cmd
        assign m_axis_tdata[g*DATA_W +: DATA_W] = r_cmd[g];
    end
    assign m_axis_tdata[AXES*DATA_W +: FLAG_W]          = r_oaflags;
    assign m_axis_tdata[AXES*DATA_W+FLAG_W +: FLAG_W]   = r_ovflags;
    assign m_axis_tdata[OUT_W-1 -: PAD_W]               = '0;

    // Checks
    assign w_vel_ext  = {w_vel_cur[DATA_W-1], w_vel_cur};
    assign w_vlim_ext = {2'b00, r_vlim};

    `APL_ASSERT_NEXT(a_accept_starts_x, s_axis_tvalid && s_axis_tready, r_state == ST_KD && r_axis == '0, "tick did not start on the first axis")
    `APL_ASSERT_NEXT(a_load_shows_result, w_load, m_axis_tvalid, "loaded result not presented")
    `APL_ASSERT_NOW(a_vel_in_limit, r_state == ST_VD, w_vel_ext <= w_vlim_ext && w_vel_ext >= -w_vlim_ext, "stored velocity outside limit")
    `APL_ASSERT_NEXT(a_last_axis_done, r_state == ST_POS && w_last, r_state == ST_DONE, "last axis did not finish the tick")

endmodule
